/* design/exp_pitch_sine_oscillator_defines.svh */
// assertion macros shared by the oscillator modules
`ifndef EXP_PITCH_SINE_OSCILLATOR_DEFINES_SVH
`define EXP_PITCH_SINE_OSCILLATOR_DEFINES_SVH

// condition must hold at every edge outside reset
`define EPSO_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("epso assertion failed");

// consequent must hold in the same cycle as the antecedent
`define EPSO_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("epso assertion failed");

// consequent must hold in the cycle after the antecedent
`define EPSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("epso assertion failed");

`endif

/* design/epso_pkg.sv */
`timescale 1ns / 1ps

package epso_pkg;

    localparam int PHASE_WIDTH      = 32;
    localparam int EXP_TABLE_DEPTH  = 256;
    localparam int SINE_TABLE_DEPTH = 1024;

    // field and register widths
    localparam int CV_W       = 17;
    localparam int OFFSET_W   = 13;
    localparam int BASE_W     = 28;
    localparam int BLINK_W    = 32;
    localparam int SINE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Q4.12 pitch
    localparam int FRAC_W      = 12;
    localparam int OCT_W       = 4;
    localparam int PITCH_LIMIT = 16384;

    // table entries are Q1.30
    localparam int ROM_FRAC = 30;
    localparam int ROM_W    = ROM_FRAC + 1;

    // step = product >> (SHIFT_BASE - octave)
    localparam int SHIFT_BASE = 34;
    localparam int SHIFT_W    = $clog2(SHIFT_BASE + 1);

    // output scaling
    localparam int MAG_MAX = 32767;
    localparam int MAG_W   = $clog2(MAG_MAX + 1);

    localparam int EXP_IDX_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;

    localparam logic [BASE_W-1:0]  BASE_INC_RESET  = BASE_W'(23409750);
    localparam logic [BLINK_W-1:0] BLINK_INC_RESET = BLINK_W'(89478);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_OFFSET    = 2'd0,
        CFG_BASE_INCREMENT  = 2'd1,
        CFG_BLINK_INCREMENT = 2'd2
    } cfg_index_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic [OCT_W-1:0]     oct;
        logic [EXP_IDX_W-1:0] k;
    } epso_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } epso_qstat_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base_increment;
        logic [BLINK_W-1:0] blink_increment;
    } epso_back_cfg_t;

    typedef logic [ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];
    typedef logic [ROM_W-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

    // 2^(k/depth) in Q1.30, truncated power series of e^(k ln2 / depth)
    function automatic exp_rom_t exp_rom_init();
        exp_rom_t    rom;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] acc;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            t    = (64'(k) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
            term = Q30_ONE;
            acc  = Q30_ONE;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * t) >> ROM_FRAC) / 64'(n);
                acc  = acc + term;
            end
            rom[k] = ROM_W'(acc);
        end
        return rom;
    endfunction

    // sin(pi/2 * i / depth) in Q1.30, truncated series, capped at one
    function automatic sine_rom_t sine_rom_init();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic        sub;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> ROM_FRAC;
            term = x;
            acc  = x;
            sub  = 1'b1;
            for (int n = 3; n <= 15; n += 2) begin
                term = ((term * x2) >> ROM_FRAC) / 64'((n - 1) * n);
                if (sub) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
                sub = !sub;
            end
            rom[i] = (acc > Q30_ONE) ? ROM_W'(Q30_ONE) : ROM_W'(acc);
        end
        return rom;
    endfunction

endpackage

/* design/epso_queue.sv */
`timescale 1ns / 1ps
`include "exp_pitch_sine_oscillator_defines.svh"

module epso_queue import epso_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  epso_cmd_t   wr_cmd,
    input  logic        pop,
    output epso_cmd_t   rd_cmd,
    output epso_qstat_t qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    epso_cmd_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rd_cmd      = mem[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

    always_comb begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    `EPSO_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `EPSO_ASSERT_SAME(a_no_push_full, aclk, aresetn, push, !qstat.full)
    `EPSO_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, pop, !qstat.empty)

endmodule

/* design/epso_front.sv */
`timescale 1ns / 1ps

module epso_front import epso_pkg::*; (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [CV_W-1:0]    s_pitch_cv,
    input  logic [OFFSET_W-1:0]       pitch_offset,
    input  epso_qstat_t               qstat,
    output logic                      push,
    output epso_cmd_t                 cmd
);

    localparam int SUM_W   = CV_W + 1;
    localparam int S_W     = OCT_W + FRAC_W;
    localparam int KPROD_W = FRAC_W + $clog2(EXP_TABLE_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] P_MAX = SUM_W'(PITCH_LIMIT);
    localparam logic signed [SUM_W-1:0] P_MIN = -P_MAX;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] clamped;
    logic [S_W-1:0]          shifted;
    logic [KPROD_W-1:0]      kprod;

    assign sum = $signed(SUM_W'(s_pitch_cv)) + $signed(SUM_W'(pitch_offset));

    // clamp to plus or minus four volts
    always_comb begin
        priority if (sum < P_MIN) begin
            clamped = P_MIN;
        end else if (sum > P_MAX) begin
            clamped = P_MAX;
        end else begin
            clamped = sum;
        end
    end

    // shift to 0..8 V, split octave and fraction
    assign shifted = S_W'(clamped + P_MAX);
    assign kprod   = KPROD_W'(shifted[FRAC_W-1:0]) * KPROD_W'(EXP_TABLE_DEPTH);
    assign cmd.oct = shifted[S_W-1:FRAC_W];
    assign cmd.k   = EXP_IDX_W'(kprod >> FRAC_W);

    assign s_ready = !qstat.full;
    assign push    = s_valid && s_ready;

endmodule

/* design/epso_back.sv */
`timescale 1ns / 1ps
`include "exp_pitch_sine_oscillator_defines.svh"

module epso_back import epso_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  epso_back_cfg_t           cfg,
    input  epso_qstat_t              qstat,
    input  epso_cmd_t                rd_cmd,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SINE_W-1:0] m_sine_out,
    output logic                     m_light_on
);

    localparam int LO_W     = 16;
    localparam int HI_W     = ROM_W - LO_W;
    localparam int PLO_W    = BASE_W + LO_W;
    localparam int PHI_W    = BASE_W + HI_W;
    localparam int PROD_W   = BASE_W + ROM_W;
    localparam int REST_W   = PHASE_WIDTH - 2;
    localparam int JPROD_W  = REST_W + $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCALE_W  = ROM_W + MAG_W;
    localparam int MWIDE_W  = SCALE_W - ROM_FRAC;

    localparam exp_rom_t  EXP_ROM  = exp_rom_init();
    localparam sine_rom_t SINE_ROM = sine_rom_init();

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_STEP,
        S_SINE,
        S_SCALE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [OCT_W-1:0]        oct_reg;
    logic [ROM_W-1:0]        exp_reg;
    logic [PLO_W-1:0]        plo_reg;
    logic [PHI_W-1:0]        phi_reg;
    logic [PHASE_WIDTH-1:0]  osc_phase_reg;
    logic [BLINK_W-1:0]      blink_phase_reg;
    logic                    light_reg;
    logic                    neg_reg;
    logic [ROM_W-1:0]        sine_rd_reg;
    logic                    m_valid_reg;
    logic [SINE_W-1:0]       m_sine_reg;
    logic                    m_light_reg;

    logic [PROD_W-1:0]       prod;
    logic [SHIFT_W-1:0]      shamt;
    logic [PHASE_WIDTH-1:0]  step;
    logic [BLINK_W-1:0]      blink_sum;
    logic [1:0]              quad;
    logic [REST_W-1:0]       rest;
    logic [JPROD_W-1:0]      jprod;
    logic [SINE_IDX_W-1:0]   j;
    logic [SINE_IDX_W-1:0]   sine_idx;
    logic [SCALE_W-1:0]      scaled;
    logic [MWIDE_W-1:0]      mag_wide;
    logic [SINE_W-1:0]       mag;
    logic [SINE_W-1:0]       sample;
    logic                    out_load;

    // frequency step from the two partial products
    assign prod  = (PROD_W'(phi_reg) << LO_W) + PROD_W'(plo_reg);
    assign shamt = SHIFT_W'(SHIFT_BASE) - SHIFT_W'(oct_reg);
    assign step  = PHASE_WIDTH'(prod >> shamt);

    assign blink_sum = blink_phase_reg + cfg.blink_increment;

    // quarter-wave addressing
    assign quad     = osc_phase_reg[PHASE_WIDTH-1 -: 2];
    assign rest     = osc_phase_reg[REST_W-1:0];
    assign jprod    = JPROD_W'(rest) * JPROD_W'(SINE_TABLE_DEPTH);
    assign j        = SINE_IDX_W'(jprod >> REST_W);
    assign sine_idx = quad[0] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - j : j;

    // v * 32767 rounded half up
    assign scaled   = (SCALE_W'(sine_rd_reg) << MAG_W) - SCALE_W'(sine_rd_reg)
                      + (SCALE_W'(1) << (ROM_FRAC - 1));
    assign mag_wide = scaled[SCALE_W-1:ROM_FRAC];
    assign mag      = (mag_wide > MWIDE_W'(MAG_MAX)) ? SINE_W'(MAG_MAX)
                                                     : SINE_W'(mag_wide);
    assign sample   = neg_reg ? SINE_W'(0) - mag : mag;

    assign pop      = (state_reg == S_IDLE) && !qstat.empty;
    assign out_load = (state_reg == S_SCALE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (pop) state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_STEP;
            S_STEP:   state_next = S_SINE;
            S_SINE:   state_next = S_SCALE;
            S_SCALE:  if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            oct_reg         <= '0;
            exp_reg         <= '0;
            plo_reg         <= '0;
            phi_reg         <= '0;
            osc_phase_reg   <= '0;
            blink_phase_reg <= '0;
            light_reg       <= 1'b0;
            neg_reg         <= 1'b0;
            sine_rd_reg     <= '0;
            m_valid_reg     <= 1'b0;
            m_sine_reg      <= '0;
            m_light_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        exp_reg <= EXP_ROM[rd_cmd.k];
                        oct_reg <= rd_cmd.oct;
                    end
                end
                S_MUL_LO: begin
                    plo_reg <= PLO_W'(cfg.base_increment) * PLO_W'(exp_reg[LO_W-1:0]);
                end
                S_MUL_HI: begin
                    phi_reg <= PHI_W'(cfg.base_increment) * PHI_W'(exp_reg[ROM_W-1:LO_W]);
                end
                S_STEP: begin
                    osc_phase_reg   <= osc_phase_reg + step;
                    blink_phase_reg <= blink_sum;
                    light_reg       <= !blink_sum[BLINK_W-1];
                end
                S_SINE: begin
                    sine_rd_reg <= SINE_ROM[sine_idx];
                    neg_reg     <= quad[1];
                end
                S_SCALE: begin
                    if (out_load) begin
                        m_sine_reg  <= sample;
                        m_light_reg <= light_reg;
                    end
                end
                default: begin
                end
            endcase
            priority if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sine_out = $signed(m_sine_reg);
    assign m_light_on = m_light_reg;

    `EPSO_ASSERT_NEXT(a_load_shows, aclk, aresetn, out_load, m_valid_reg)
    `EPSO_ASSERT_NEXT(a_phase_hold, aclk, aresetn, state_reg != S_STEP, $stable(osc_phase_reg))
    `EPSO_ASSERT_NEXT(a_idle_wait, aclk, aresetn, state_reg == S_IDLE && qstat.empty, state_reg == S_IDLE)

endmodule

/* design/exp_pitch_sine_oscillator.sv */
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// cfg       in   cfg_we             cfg_index, cfg_wdata
// s (cv)    in   s_valid / s_ready  s_pitch_cv
// m (out)   out  m_valid / m_ready  m_sine_out, m_light_on
//
// the back sequencer takes a sample through table read, two partial
// products of the 28x31 frequency multiply, phase step, sine table read, scaling
// the front takes a new transaction whenever the two-entry queue has room
// aresetn is synchronous; reset clears both phases and loads the default registers
// a stalled result holds the back in its last step; the front keeps filling the queue

module exp_pitch_sine_oscillator import epso_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [CV_W-1:0]   s_pitch_cv,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SINE_W-1:0] m_sine_out,
    output logic                     m_light_on
);

    // configuration registers
    logic [OFFSET_W-1:0] pitch_offset_reg;
    logic [BASE_W-1:0]   base_increment_reg;
    logic [BLINK_W-1:0]  blink_increment_reg;

    // front to queue to back
    epso_qstat_t    qstat;
    epso_cmd_t      wr_cmd;
    epso_cmd_t      rd_cmd;
    logic           push;
    logic           pop;
    epso_back_cfg_t back_cfg;

    // register writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_offset_reg    <= '0;
            base_increment_reg  <= BASE_INC_RESET;
            blink_increment_reg <= BLINK_INC_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PITCH_OFFSET:    pitch_offset_reg    <= cfg_wdata[OFFSET_W-1:0];
                CFG_BASE_INCREMENT:  base_increment_reg  <= cfg_wdata[BASE_W-1:0];
                CFG_BLINK_INCREMENT: blink_increment_reg <= cfg_wdata[BLINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.base_increment  = base_increment_reg;
    assign back_cfg.blink_increment = blink_increment_reg;

    // front: sum with knob offset, clamp, split into octave and table index
    epso_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pitch_cv   (s_pitch_cv),
        .pitch_offset (pitch_offset_reg),
        .qstat        (qstat),
        .push         (push),
        .cmd          (wr_cmd)
    );

    // short queue decoupling the input from the sequencer
    epso_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (wr_cmd),
        .pop     (pop),
        .rd_cmd  (rd_cmd),
        .qstat   (qstat)
    );

    // back: exponential step, phase accumulators, sine lookup, output register
    epso_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (back_cfg),
        .qstat      (qstat),
        .rd_cmd     (rd_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sine_out (m_sine_out),
        .m_light_on (m_light_on)
    );

endmodule

/* test/exp_pitch_sine_oscillator_test.sv */
`timescale 1ns / 1ps

module exp_pitch_sine_oscillator_test;
    import epso_pkg::*;

    // run limits
    localparam int LIMIT_CYCLES    = 1000000;
    localparam int SETTLE_CYCLES   = 24;      // back sequencer plus two-entry queue
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 200;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 2'd3;

    // table math in Q1.30
    localparam logic [63:0] ONE_Q30       = 64'd1 << ROM_FRAC;
    localparam logic [63:0] LOG2E_INV_Q30 = 64'd744261118;    // ln 2
    localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;   // pi / 2

    // dut ports; the inputs are all known from time zero
    logic                     aclk;
    logic                     aresetn    = 1'b0;
    logic                     cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata  = '0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic signed [CV_W-1:0]   s_pitch_cv = '0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic signed [SINE_W-1:0] m_sine_out;
    logic                     m_light_on;

    exp_pitch_sine_oscillator uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pitch_cv (s_pitch_cv),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sine_out (m_sine_out),
        .m_light_on (m_light_on)
    );

    // one expected output sample
    typedef struct packed {
        logic signed [SINE_W-1:0] sine;
        logic                     light;
    } osc_sample_t;

    // register set used by the directed rows
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [BASE_W-1:0]   base;
        logic [BLINK_W-1:0]  blink;
    } osc_setting_t;

    // directed row: setting to use, control voltage, and an optional typed-in result
    typedef struct packed {
        logic [1:0]               setting;
        logic signed [CV_W-1:0]   cv;
        logic                     known;
        logic signed [SINE_W-1:0] sine;
        logic                     light;
    } cv_row_t;

    // setting 0 freezes the oscillator at phase zero and flips the light every sample
    // setting 1 is the power-up tuning with a one volt knob
    // setting 2 pushes the knob past one volt, the base step and the blink step to the top
    localparam osc_setting_t DIRECTED_SETTINGS [3] = '{
        '{13'd0,    28'd0,         32'h8000_0000},
        '{13'd4096, 28'd23409750,  32'd89478},
        '{13'd8191, 28'hFFF_FFFF,  32'hFFFF_FFFF}
    };

    localparam int DIRECTED_ROWS = 22;
    localparam cv_row_t CV_SCRIPT [DIRECTED_ROWS] = '{
        // frozen phase: silent output, light toggles from the reset blink phase
        '{2'd0, -40960, 1'b1, 0, 1'b0},     // field minimum
        '{2'd0,  40959, 1'b1, 0, 1'b1},     // field maximum
        '{2'd0, -65536, 1'b1, 0, 1'b0},     // most negative 17-bit pattern
        '{2'd0,  65535, 1'b1, 0, 1'b1},     // most positive 17-bit pattern
        '{2'd0,      0, 1'b1, 0, 1'b0},
        '{2'd0,     -1, 1'b1, 0, 1'b1},
        // default tuning, one volt knob
        '{2'd1, -20480, 1'b0, 0, 1'b0},     // sum exactly at -4 V
        '{2'd1, -20481, 1'b0, 0, 1'b0},     // one lsb below the clamp
        '{2'd1,  12288, 1'b0, 0, 1'b0},     // sum exactly at +4 V
        '{2'd1,  12289, 1'b0, 0, 1'b0},     // one lsb above the clamp
        '{2'd1,  -4096, 1'b0, 0, 1'b0},     // middle c
        '{2'd1,      0, 1'b0, 0, 1'b0},
        '{2'd1,   2047, 1'b0, 0, 1'b0},
        '{2'd1,  -2049, 1'b0, 0, 1'b0},
        // knob above one volt, largest base step, blink step wraps every sample
        '{2'd2,  40959, 1'b0, 0, 1'b0},
        '{2'd2, -24575, 1'b0, 0, 1'b0},     // sum exactly at -4 V
        '{2'd2, -24576, 1'b0, 0, 1'b0},
        '{2'd2,   8193, 1'b0, 0, 1'b0},     // sum exactly at +4 V
        '{2'd2,  65535, 1'b0, 0, 1'b0},
        '{2'd2, -65536, 1'b0, 0, 1'b0},
        '{2'd2,   4095, 1'b0, 0, 1'b0},
        '{2'd2,     16, 1'b0, 0, 1'b0}
    };

    // predictor state: tables, registers and the two accumulators
    logic [ROM_W-1:0]       pow2_frac_tab    [EXP_TABLE_DEPTH];
    logic [ROM_W-1:0]       quarter_sine_tab [SINE_TABLE_DEPTH + 1];
    logic [OFFSET_W-1:0]    offset_reg = '0;
    logic [BASE_W-1:0]      base_reg   = BASE_W'(23409750);
    logic [BLINK_W-1:0]     blink_reg  = BLINK_W'(89478);
    logic [PHASE_WIDTH-1:0] osc_acc    = '0;
    logic [31:0]            blink_acc  = '0;

    osc_sample_t pending_samples [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    logic        no_gaps     = 1'b0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("exp_pitch_sine_oscillator_test NOT OK");
            $finish;
        end
    end

    task automatic note_failure(input string what);
        if (fail_count < 10) begin
            $display("%s", what);
        end
        fail_count++;
    endtask

    // fraction table 2^(k/depth) and quarter-wave table, both truncated series in Q1.30
    task automatic build_tables();
        logic [63:0] t;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic        minus;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            t    = (64'(k) * LOG2E_INV_Q30) / 64'(EXP_TABLE_DEPTH);
            term = ONE_Q30;
            acc  = ONE_Q30;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * t) >> ROM_FRAC) / 64'(n);
                acc  = acc + term;
            end
            pow2_frac_tab[k] = acc[ROM_W-1:0];
        end
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            t     = (64'(i) * QUARTER_TURN) / 64'(SINE_TABLE_DEPTH);
            x2    = (t * t) >> ROM_FRAC;
            term  = t;
            acc   = t;
            minus = 1'b1;
            for (int n = 3; n <= 15; n += 2) begin
                term = ((term * x2) >> ROM_FRAC) / 64'((n - 1) * n);
                if (minus) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
                minus = !minus;
            end
            if (acc > ONE_Q30) begin
                acc = ONE_Q30;
            end
            quarter_sine_tab[i] = acc[ROM_W-1:0];
        end
    endtask

    // one sample tick: pitch to phase step, phase to sine, blink phase to light
    task automatic advance_oscillator(input logic signed [CV_W-1:0] cv,
                                      output osc_sample_t sample);
        int                       pitch;
        int                       octave;
        int                       frac;
        int                       k;
        int                       j;
        logic [63:0]              prod;
        logic [63:0]              mag;
        logic [ROM_W-1:0]         v;
        logic [1:0]               quad;
        logic signed [SINE_W-1:0] mag16;
        pitch = int'(cv) + int'(offset_reg);
        if (pitch < -PITCH_LIMIT) begin
            pitch = -PITCH_LIMIT;
        end
        if (pitch > PITCH_LIMIT) begin
            pitch = PITCH_LIMIT;
        end
        pitch  = pitch + PITCH_LIMIT;
        octave = pitch >> FRAC_W;
        frac   = pitch & ((1 << FRAC_W) - 1);
        k      = (frac * EXP_TABLE_DEPTH) >> FRAC_W;
        prod   = (64'(base_reg) * 64'(pow2_frac_tab[k])) >> (SHIFT_BASE - octave);
        // step wraps to the phase width
        osc_acc = osc_acc + prod[PHASE_WIDTH-1:0];

        quad = osc_acc[PHASE_WIDTH-1 -: 2];
        j    = int'((64'(osc_acc[PHASE_WIDTH-3:0]) * 64'(SINE_TABLE_DEPTH))
                    >> (PHASE_WIDTH - 2));
        v    = quad[0] ? quarter_sine_tab[SINE_TABLE_DEPTH - j] : quarter_sine_tab[j];
        mag  = (64'(v) * 64'(MAG_MAX) + (64'd1 << (ROM_FRAC - 1))) >> ROM_FRAC;
        if (mag > 64'(MAG_MAX)) begin
            mag = 64'(MAG_MAX);
        end
        mag16        = mag[SINE_W-1:0];
        sample.sine  = quad[1] ? -mag16 : mag16;

        blink_acc    = blink_acc + blink_reg;
        sample.light = ~blink_acc[31];
    endtask

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // one register write; the caller drops cfg_we after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_PITCH_OFFSET:    offset_reg = data[OFFSET_W-1:0];
            CFG_BASE_INCREMENT:  base_reg   = data[BASE_W-1:0];
            CFG_BLINK_INCREMENT: blink_reg  = data[BLINK_W-1:0];
            default: ;
        endcase
    endtask

    // all three registers plus a stray write, with junk above the offset and base widths
    task automatic apply_settings(input osc_setting_t cfg);
        logic [CFG_DATA_W-1:0] data;
        data                 = $urandom;
        data[OFFSET_W-1:0]   = cfg.offset;
        write_reg(CFG_PITCH_OFFSET, data);
        write_reg(CFG_NO_REGISTER, $urandom);
        data                 = $urandom;
        data[BASE_W-1:0]     = cfg.base;
        write_reg(CFG_BASE_INCREMENT, data);
        write_reg(CFG_BLINK_INCREMENT, cfg.blink);
        cfg_we <= 1'b0;
    endtask

    // stop sending and let every pending sample come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // present one control voltage, wait for the transaction, record what should come out
    task automatic send_sample(input logic signed [CV_W-1:0] cv, input logic known,
                               input logic signed [SINE_W-1:0] sine, input logic light);
        int          gap;
        osc_sample_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pitch_cv <= cv;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        advance_oscillator(cv, want);
        if (known) begin
            want.sine  = sine;
            want.light = light;
        end
        pending_samples.push_back(want);
    endtask

    // random register set, extremes weighted in
    function automatic osc_setting_t random_settings();
        osc_setting_t cfg;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            cfg.offset = '0;
        end else if (r < 30) begin
            cfg.offset = OFFSET_W'(4096);
        end else if (r < 45) begin
            cfg.offset = '1;
        end else if (r < 85) begin
            cfg.offset = OFFSET_W'($urandom_range(0, 4096));
        end else begin
            cfg.offset = OFFSET_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            cfg.base = '0;
        end else if (r < 20) begin
            cfg.base = '1;
        end else if (r < 40) begin
            cfg.base = BASE_W'(23409750);
        end else if (r < 60) begin
            cfg.base = BASE_W'($urandom_range(0, 65535));
        end else begin
            cfg.base = BASE_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            cfg.blink = '0;
        end else if (r < 20) begin
            cfg.blink = '1;
        end else if (r < 30) begin
            cfg.blink = 32'h8000_0000;
        end else if (r < 50) begin
            cfg.blink = BLINK_W'(89478);
        end else begin
            cfg.blink = $urandom;
        end
        return cfg;
    endfunction

    // control voltage: mostly in range, some at the clamp, some any 17-bit pattern
    function automatic logic signed [CV_W-1:0] random_cv();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            v = int'($urandom_range(0, 81919)) - 40960;
        end else if (r < 70) begin
            v = ($urandom_range(0, 1) ? PITCH_LIMIT : -PITCH_LIMIT) - int'(offset_reg)
                + int'($urandom_range(0, 8)) - 4;
        end else if (r < 85) begin
            v = int'($urandom_range(0, 8192)) - 4096;
        end else begin
            v = int'($urandom);
        end
        return CV_W'(v);
    endfunction

    // sink side: random back-pressure, long stalls now and then
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // output checker: every transaction against the oldest pending sample
    always @(posedge aclk) begin : check_output
        osc_sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                note_failure($sformatf("unexpected sample: sine %0d light %0b",
                                       m_sine_out, m_light_on));
            end else begin
                want = pending_samples.pop_front();
                if (m_sine_out !== want.sine || m_light_on !== want.light) begin
                    note_failure($sformatf("sample mismatch: sine exp %0d got %0d, light exp %0b got %0b",
                                           want.sine, m_sine_out, want.light, m_light_on));
                end
            end
        end
    end

    // main sequence
    initial begin
        logic [1:0] active_setting;
        build_tables();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, settings change between groups while the block is idle
        active_setting = 2'd3;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (CV_SCRIPT[i].setting != active_setting) begin
                wait_idle();
                active_setting = CV_SCRIPT[i].setting;
                apply_settings(DIRECTED_SETTINGS[active_setting]);
            end
            send_sample(CV_SCRIPT[i].cv, CV_SCRIPT[i].known,
                        CV_SCRIPT[i].sine, CV_SCRIPT[i].light);
        end

        // random phases, each with its own register set; every third runs without gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            apply_settings(random_settings());
            no_gaps = (ph % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sample(random_cv(), 1'b0, '0, 1'b0);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_samples.size() == 0) begin
            $display("exp_pitch_sine_oscillator_test OK");
        end else begin
            $display("exp_pitch_sine_oscillator_test NOT OK");
        end
        $finish;
    end

endmodule
